### hdl/lfps_pkg.sv
// ----------------------------------------------------------------------------
// lfps_pkg: shared constants and types for the line follower steering block
// Sizes, fixed-point scaling, register codes and pipeline control bundles.
// ----------------------------------------------------------------------------
package lfps_pkg;

  // Sensor array
  localparam int SENSOR_COUNT = 8;
  localparam int SAMPLE_BITS  = 10;
  localparam int IN_DATA_W    = ((SENSOR_COUNT * SAMPLE_BITS + 7) / 8) * 8;

  // Line error in units of 1/40 of a sensor pitch: sensor i adds 40*i - 131
  localparam int POS_SCALE  = 40;
  localparam int POS_OFFSET = 131;
  localparam int CONTRIB_W  = 10;
  localparam int ERR_W      = 10;
  localparam int ERR_SUM_W  = CONTRIB_W + $clog2(SENSOR_COUNT);
  localparam int ERR_MAX    = (1 << (ERR_W - 1)) - 1;
  localparam int ERR_MIN    = -(1 << (ERR_W - 1));

  // PID datapath
  localparam int SUM_W  = 24;
  localparam int DIFF_W = ERR_W + 1;
  localparam int GAIN_W = 16;
  localparam int P_W    = GAIN_W + 1 + ERR_W;
  localparam int I_W    = GAIN_W + 1 + SUM_W;
  localparam int D_W    = GAIN_W + 1 + DIFF_W;
  localparam int ACC_W  = I_W + 2;

  // Divide by 256*40 = 2^11 * 5: shift, then reciprocal multiply for the 5
  localparam int          GAIN_FRAC_BITS = 8;
  localparam int          SCALE_SHIFT    = GAIN_FRAC_BITS + 3;
  localparam int          MAG_W          = ACC_W - SCALE_SHIFT;
  localparam int          RECIP_W        = 32;
  localparam logic [RECIP_W-1:0] RECIP_FIVE = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT    = RECIP_W + 2;
  localparam int          PROD_W         = MAG_W + RECIP_W;
  localparam int          Q_W            = PROD_W - RECIP_SHIFT;
  localparam int          CORR_W         = 9;
  localparam int          CORR_MAX       = (1 << CORR_W) - 1;

  // Wheel drive
  localparam int SPEED_W    = 8;
  localparam int DRV_W      = SPEED_W + 3;
  localparam int OUT_DATA_W = 2 * SPEED_W;
  localparam logic [SPEED_W-1:0] DARK_LEFT  = 8'd207;
  localparam logic [SPEED_W-1:0] DARK_RIGHT = 8'd200;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam logic [SAMPLE_BITS-1:0] THRESH_RST = 10'd600;
  localparam logic [GAIN_W-1:0]      PROP_RST   = 16'd1792;
  localparam logic [GAIN_W-1:0]      INTEG_RST  = 16'd0;
  localparam logic [GAIN_W-1:0]      DERIV_RST  = 16'd128;
  localparam logic [SPEED_W-1:0]     BASE_RST   = 8'd150;
  localparam logic [SPEED_W-1:0]     MIN_RST    = 8'd0;
  localparam logic [SPEED_W-1:0]     MAX_RST    = 8'd255;

  typedef enum logic [2:0] {
    REG_DARK_THRESHOLD    = 3'd0,
    REG_PROP_GAIN         = 3'd1,
    REG_INTEG_GAIN        = 3'd2,
    REG_DERIV_GAIN        = 3'd3,
    REG_BASE_SPEED        = 3'd4,
    REG_MIN_SPEED         = 3'd5,
    REG_MAX_SPEED         = 3'd6,
    REG_ALL_DARK_OVERRIDE = 3'd7
  } reg_idx_t;

  // Pipeline stages, input to output
  localparam int STG_LANE  = 0;
  localparam int STG_MERGE = 1;
  localparam int STG_STATE = 2;
  localparam int STG_MUL   = 3;
  localparam int STG_ACC   = 4;
  localparam int STG_ABS   = 5;
  localparam int STG_DIV   = 6;
  localparam int STG_OUT   = 7;
  localparam int NUM_STAGES = 8;

  typedef logic signed [CONTRIB_W-1:0] contrib_t;
  typedef logic signed [ERR_W-1:0]     err_t;
  typedef logic signed [ACC_W-1:0]     acc_t;

  typedef struct packed {
    logic in_valid;
    logic en_state;
    logic en_mul;
    logic en_acc;
  } pid_ctl_t;

  typedef struct packed {
    logic en_abs;
    logic en_div;
    logic en_out;
  } drv_ctl_t;

  function automatic contrib_t lane_weight(input int idx);
    return contrib_t'(POS_SCALE * idx - POS_OFFSET);
  endfunction

endpackage

### hdl/lfps_lane.sv
// ----------------------------------------------------------------------------
// lfps_lane: one sensor lane
// Compares a sample with the dark threshold and registers its error weight.
// ----------------------------------------------------------------------------
module lfps_lane import lfps_pkg::*; (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SAMPLE_BITS-1:0] threshold,
  input  contrib_t               weight,
  output logic                   hit_r,
  output contrib_t               contrib_r
);

  logic     hit_nxt;
  contrib_t contrib_nxt;

  assign hit_nxt     = (sample > threshold);
  assign contrib_nxt = hit_nxt ? weight : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r     <= hit_nxt;
      contrib_r <= contrib_nxt;
    end
  end

endmodule

### hdl/lfps_merge.sv
// ----------------------------------------------------------------------------
// lfps_merge: lane merge
// Adds the lane weights into the line error, saturates it, flags all-dark.
// ----------------------------------------------------------------------------
module lfps_merge import lfps_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic [SENSOR_COUNT-1:0] hits,
  input  contrib_t                contribs [SENSOR_COUNT],
  output err_t                    err_r,
  output logic                    all_dark_r
);

  localparam logic signed [ERR_SUM_W-1:0] SAT_HI = ERR_SUM_W'(ERR_MAX);
  localparam logic signed [ERR_SUM_W-1:0] SAT_LO = ERR_SUM_W'(ERR_MIN);

  logic signed [ERR_SUM_W-1:0] total;
  err_t                        err_nxt;

  always_comb begin
    total = '0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      total = total + ERR_SUM_W'(contribs[i]);
    end
    if (total > SAT_HI) begin
      err_nxt = ERR_W'(ERR_MAX);
    end else if (total < SAT_LO) begin
      err_nxt = ERR_W'(ERR_MIN);
    end else begin
      err_nxt = total[ERR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      err_r      <= err_nxt;
      all_dark_r <= &hits;
    end
  end

endmodule

### hdl/lfps_pid.sv
// ----------------------------------------------------------------------------
// lfps_pid: PID core
// Updates the integral and last error, forms the three gain products and sums.
// ----------------------------------------------------------------------------
module lfps_pid import lfps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  pid_ctl_t          ctl,
  input  err_t              err,
  input  logic              all_dark,
  input  logic              ovr_en,
  input  logic [GAIN_W-1:0] prop_gain,
  input  logic [GAIN_W-1:0] integ_gain,
  input  logic [GAIN_W-1:0] deriv_gain,
  output acc_t              acc_r,
  output logic              ovr_r
);

  localparam logic signed [SUM_W:0] SUM_HI = (SUM_W + 1)'((1 << (SUM_W - 1)) - 1);
  localparam logic signed [SUM_W:0] SUM_LO = (SUM_W + 1)'(-(1 << (SUM_W - 1)));

  // Controller state
  logic signed [SUM_W-1:0]  error_sum_r;
  err_t                     prior_error_r;

  // State stage
  logic                     ovr_nxt;
  logic signed [SUM_W:0]    sum_ext;
  logic signed [SUM_W-1:0]  sum_nxt;
  logic signed [DIFF_W-1:0] diff_nxt;
  err_t                     err_a_r;
  logic signed [SUM_W-1:0]  sum_a_r;
  logic signed [DIFF_W-1:0] diff_a_r;
  logic                     ovr_a_r;

  // Multiply stage
  logic signed [P_W-1:0]    p_nxt;
  logic signed [I_W-1:0]    i_nxt;
  logic signed [D_W-1:0]    d_nxt;
  logic signed [P_W-1:0]    p_r;
  logic signed [I_W-1:0]    i_r;
  logic signed [D_W-1:0]    d_r;
  logic                     ovr_b_r;

  acc_t                     acc_nxt;

  assign ovr_nxt  = ovr_en & all_dark;
  assign sum_ext  = (SUM_W + 1)'(error_sum_r) + (SUM_W + 1)'(err);
  assign diff_nxt = DIFF_W'(err) - DIFF_W'(prior_error_r);

  always_comb begin
    if (sum_ext > SUM_HI) begin
      sum_nxt = SUM_HI[SUM_W-1:0];
    end else if (sum_ext < SUM_LO) begin
      sum_nxt = SUM_LO[SUM_W-1:0];
    end else begin
      sum_nxt = sum_ext[SUM_W-1:0];
    end
  end

  // Integral and last error change once per item, as it enters; override skips
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r   <= '0;
      prior_error_r <= '0;
    end else if (ctl.en_state && ctl.in_valid && !ovr_nxt) begin
      error_sum_r   <= sum_nxt;
      prior_error_r <= err;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en_state) begin
      err_a_r  <= err;
      sum_a_r  <= sum_nxt;
      diff_a_r <= diff_nxt;
      ovr_a_r  <= ovr_nxt;
    end
  end

  assign p_nxt = $signed({1'b0, prop_gain})  * err_a_r;
  assign i_nxt = $signed({1'b0, integ_gain}) * sum_a_r;
  assign d_nxt = $signed({1'b0, deriv_gain}) * diff_a_r;

  always_ff @(posedge clk) begin
    if (ctl.en_mul) begin
      p_r     <= p_nxt;
      i_r     <= i_nxt;
      d_r     <= d_nxt;
      ovr_b_r <= ovr_a_r;
    end
  end

  assign acc_nxt = ACC_W'(p_r) + ACC_W'(i_r) + ACC_W'(d_r);

  always_ff @(posedge clk) begin
    if (ctl.en_acc) begin
      acc_r <= acc_nxt;
      ovr_r <= ovr_b_r;
    end
  end

endmodule

### hdl/lfps_drive.sv
// ----------------------------------------------------------------------------
// lfps_drive: correction scaling and wheel drive
// Divides the PID sum by 10240 toward zero, steers both wheels and clamps.
// ----------------------------------------------------------------------------
module lfps_drive import lfps_pkg::*; (
  input  logic               clk,
  input  drv_ctl_t           ctl,
  input  acc_t               acc,
  input  logic               ovr,
  input  logic [SPEED_W-1:0] base_speed,
  input  logic [SPEED_W-1:0] min_speed,
  input  logic [SPEED_W-1:0] max_speed,
  output logic [SPEED_W-1:0] left_r,
  output logic [SPEED_W-1:0] right_r,
  output logic               ovr_r
);

  // Magnitude stage
  logic                    neg_nxt;
  logic [ACC_W-1:0]        abs_acc;
  logic [MAG_W-1:0]        mag_r;
  logic                    neg_a_r;
  logic                    ovr_a_r;

  // Reciprocal stage
  logic [PROD_W-1:0]       prod_nxt;
  logic [PROD_W-1:0]       prod_r;
  logic                    neg_b_r;
  logic                    ovr_b_r;

  // Steering stage
  logic [Q_W-1:0]          quot;
  logic [CORR_W-1:0]       corr;
  logic signed [DRV_W-1:0] base_ext;
  logic signed [DRV_W-1:0] corr_ext;
  logic signed [DRV_W-1:0] left_v;
  logic signed [DRV_W-1:0] right_v;
  logic [SPEED_W-1:0]      left_nxt;
  logic [SPEED_W-1:0]      right_nxt;

  function automatic logic [SPEED_W-1:0] clamp_drive(
    input logic signed [DRV_W-1:0] v,
    input logic [SPEED_W-1:0]      lo,
    input logic [SPEED_W-1:0]      hi
  );
    logic signed [DRV_W-1:0] t;
    logic signed [DRV_W-1:0] lo_ext;
    logic signed [DRV_W-1:0] hi_ext;
    lo_ext = $signed({{(DRV_W - SPEED_W){1'b0}}, lo});
    hi_ext = $signed({{(DRV_W - SPEED_W){1'b0}}, hi});
    t = v;
    if (t < lo_ext) t = lo_ext;
    if (t > hi_ext) t = hi_ext;
    return t[SPEED_W-1:0];
  endfunction

  assign neg_nxt = acc[ACC_W-1];
  assign abs_acc = neg_nxt ? ACC_W'(-acc) : ACC_W'(acc);

  always_ff @(posedge clk) begin
    if (ctl.en_abs) begin
      mag_r   <= abs_acc[ACC_W-1:SCALE_SHIFT];
      neg_a_r <= neg_nxt;
      ovr_a_r <= ovr;
    end
  end

  // floor(x/5) = (x * 0xCCCCCCCD) >> 34 for any 32-bit x
  assign prod_nxt = PROD_W'(mag_r) * PROD_W'(RECIP_FIVE);

  always_ff @(posedge clk) begin
    if (ctl.en_div) begin
      prod_r  <= prod_nxt;
      neg_b_r <= neg_a_r;
      ovr_b_r <= ovr_a_r;
    end
  end

  // Any correction past the drive range clamps the same way, so cap it
  assign quot     = prod_r[PROD_W-1:RECIP_SHIFT];
  assign corr     = (quot > Q_W'(CORR_MAX)) ? CORR_W'(CORR_MAX) : quot[CORR_W-1:0];
  assign base_ext = $signed({{(DRV_W - SPEED_W){1'b0}}, base_speed});
  assign corr_ext = $signed({{(DRV_W - CORR_W){1'b0}}, corr});
  assign left_v   = neg_b_r ? base_ext + corr_ext : base_ext - corr_ext;
  assign right_v  = neg_b_r ? base_ext - corr_ext : base_ext + corr_ext;

  assign left_nxt  = ovr_b_r ? DARK_LEFT  : clamp_drive(left_v,  min_speed, max_speed);
  assign right_nxt = ovr_b_r ? DARK_RIGHT : clamp_drive(right_v, min_speed, max_speed);

  always_ff @(posedge clk) begin
    if (ctl.en_out) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
      ovr_r   <= ovr_b_r;
    end
  end

endmodule

### hdl/line_follow_pid_steering.sv
// ----------------------------------------------------------------------------
// line_follow_pid_steering: PID steering for a line follower
// Eight-lane sensor front end, PID core and wheel drive with APB registers.
// ----------------------------------------------------------------------------
// Each item carries eight reflectance samples. One lane per sensor compares its
// sample with dark_threshold; the merge stage adds 40*i - 131 for every sensor
// on the line, giving the line error in 1/40 of a sensor pitch. The PID core
// then updates the saturating 24-bit integral and the last error, multiplies by
// the Q8.8 gains and sums; the drive stage divides by 10240 toward zero and
// sets left = base - correction, right = base + correction, each clamped to
// [min_speed, max_speed] (min first, then max). With all_dark_override set and
// all eight sensors dark the item yields 207/200 with out_tuser high, and the
// integral and last error stay as they were. The block is an eight-stage
// pipeline: a new item can be taken every cycle while out_tready is high or a
// stage has room; the integral update, done as each item enters the PID core,
// is what lets items follow back to back. Each stage holds its item while the
// one after it is full and cannot move on, so bubbles close up and in_tready
// stays high while the output register waits, until every stage holds an
// item. Write registers only while no item is in flight.
// ----------------------------------------------------------------------------
module line_follow_pid_steering import lfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,

  // Sensor items
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // sense_0 .. sense_7, 10 bits each, sense_0 lowest

  // Drive items
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // left_drive [7:0], right_drive [15:8]
  output logic                  out_tuser,  // override_taken

  // Register port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // ---------------- configuration registers ----------------
  logic [SAMPLE_BITS-1:0] dark_threshold_r;
  logic [GAIN_W-1:0]      prop_gain_r;
  logic [GAIN_W-1:0]      integ_gain_r;
  logic [GAIN_W-1:0]      deriv_gain_r;
  logic [SPEED_W-1:0]     base_speed_r;
  logic [SPEED_W-1:0]     min_speed_r;
  logic [SPEED_W-1:0]     max_speed_r;
  logic                   all_dark_override_r;

  logic                   cfg_wr;
  reg_idx_t               cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dark_threshold_r    <= THRESH_RST;
      prop_gain_r         <= PROP_RST;
      integ_gain_r        <= INTEG_RST;
      deriv_gain_r        <= DERIV_RST;
      base_speed_r        <= BASE_RST;
      min_speed_r         <= MIN_RST;
      max_speed_r         <= MAX_RST;
      all_dark_override_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DARK_THRESHOLD:    dark_threshold_r    <= cfg_pwdata[SAMPLE_BITS-1:0];
        REG_PROP_GAIN:         prop_gain_r         <= cfg_pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN:        integ_gain_r        <= cfg_pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN:        deriv_gain_r        <= cfg_pwdata[GAIN_W-1:0];
        REG_BASE_SPEED:        base_speed_r        <= cfg_pwdata[SPEED_W-1:0];
        REG_MIN_SPEED:         min_speed_r         <= cfg_pwdata[SPEED_W-1:0];
        REG_MAX_SPEED:         max_speed_r         <= cfg_pwdata[SPEED_W-1:0];
        REG_ALL_DARK_OVERRIDE: all_dark_override_r <= cfg_pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DARK_THRESHOLD:    cfg_prdata = CFG_DATA_W'(dark_threshold_r);
      REG_PROP_GAIN:         cfg_prdata = CFG_DATA_W'(prop_gain_r);
      REG_INTEG_GAIN:        cfg_prdata = CFG_DATA_W'(integ_gain_r);
      REG_DERIV_GAIN:        cfg_prdata = CFG_DATA_W'(deriv_gain_r);
      REG_BASE_SPEED:        cfg_prdata = CFG_DATA_W'(base_speed_r);
      REG_MIN_SPEED:         cfg_prdata = CFG_DATA_W'(min_speed_r);
      REG_MAX_SPEED:         cfg_prdata = CFG_DATA_W'(max_speed_r);
      REG_ALL_DARK_OVERRIDE: cfg_prdata = CFG_DATA_W'(all_dark_override_r);
    endcase
  end

  // ---------------- pipeline occupancy ----------------
  // A stage loads when it is empty or the stage after it moves on.
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  logic [NUM_STAGES-1:0] adv;

  always_comb begin
    adv[STG_OUT] = ~valid_r[STG_OUT] | out_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      adv[k] = ~valid_r[k] | adv[k+1];
    end
    valid_nxt[STG_LANE] = adv[STG_LANE] ? in_tvalid : valid_r[STG_LANE];
    for (int k = 1; k < NUM_STAGES; k++) begin
      valid_nxt[k] = adv[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_tready  = adv[STG_LANE];
  assign out_tvalid = valid_r[STG_OUT];

  // ---------------- sensor lanes ----------------
  logic [SENSOR_COUNT-1:0] hits;
  contrib_t                contribs [SENSOR_COUNT];

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_lane
    lfps_lane u_lane (
      .clk       (clk),
      .en        (adv[STG_LANE]),
      .sample    (in_tdata[g*SAMPLE_BITS +: SAMPLE_BITS]),
      .threshold (dark_threshold_r),
      .weight    (lane_weight(g)),
      .hit_r     (hits[g]),
      .contrib_r (contribs[g])
    );
  end

  // ---------------- merge ----------------
  err_t line_err;
  logic all_dark;

  lfps_merge u_merge (
    .clk        (clk),
    .en         (adv[STG_MERGE]),
    .hits       (hits),
    .contribs   (contribs),
    .err_r      (line_err),
    .all_dark_r (all_dark)
  );

  // ---------------- PID ----------------
  pid_ctl_t pid_ctl;
  acc_t     pid_acc;
  logic     pid_ovr;

  assign pid_ctl.in_valid = valid_r[STG_MERGE];
  assign pid_ctl.en_state = adv[STG_STATE];
  assign pid_ctl.en_mul   = adv[STG_MUL];
  assign pid_ctl.en_acc   = adv[STG_ACC];

  lfps_pid u_pid (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (pid_ctl),
    .err        (line_err),
    .all_dark   (all_dark),
    .ovr_en     (all_dark_override_r),
    .prop_gain  (prop_gain_r),
    .integ_gain (integ_gain_r),
    .deriv_gain (deriv_gain_r),
    .acc_r      (pid_acc),
    .ovr_r      (pid_ovr)
  );

  // ---------------- wheel drive ----------------
  drv_ctl_t           drv_ctl;
  logic [SPEED_W-1:0] left_drive;
  logic [SPEED_W-1:0] right_drive;
  logic               override_taken;

  assign drv_ctl.en_abs = adv[STG_ABS];
  assign drv_ctl.en_div = adv[STG_DIV];
  assign drv_ctl.en_out = adv[STG_OUT];

  lfps_drive u_drive (
    .clk        (clk),
    .ctl        (drv_ctl),
    .acc        (pid_acc),
    .ovr        (pid_ovr),
    .base_speed (base_speed_r),
    .min_speed  (min_speed_r),
    .max_speed  (max_speed_r),
    .left_r     (left_drive),
    .right_r    (right_drive),
    .ovr_r      (override_taken)
  );

  assign out_tdata = {right_drive, left_drive};
  assign out_tuser = override_taken;

endmodule
